// ===== sv/lgpd_pkg.sv =====
package lgpd_pkg;

   localparam int SENSORS     = 4;
   localparam int IDX_W       = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int TRK_W       = $clog2(SENSORS + 1);
   localparam int SAMPLE_W    = 10;
   localparam int TIME_W      = 32;
   localparam int CSR_IDX_W   = $clog2(2 * SENSORS);
   localparam int CSR_DATA_W  = 10;
   localparam int PASS_SENS_W = 2;
   localparam int TRACK_OUT_W = 3;

   localparam logic [TRK_W-1:0] NO_SENSOR = TRK_W'(SENSORS);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef sample_type [SENSORS-1:0] sample_arr_type;

   // outcome of the candidate scan for one item
   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   chosen;
      logic               below_detect;
      logic [SENSORS-1:0] adapt;
   } sel_type;

   typedef struct packed {
      logic                   fire;
      logic [PASS_SENS_W-1:0] pass_sensor;
      logic [TIME_W-1:0]      pass_duration;
      logic [TRK_W-1:0]       tracking_sensor;
   } res_type;

endpackage

// ===== sv/lgpd_csr.sv =====
module lgpd_csr import lgpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  step_en,
   input  logic [SENSORS-1:0]    adapt,
   input  sample_arr_type        readings,
   output sample_arr_type        detect_level,
   output sample_arr_type        noise_level
);

   sample_arr_type detect_ff;
   sample_arr_type noise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_ff <= '0;
         noise_ff  <= '0;
      end else begin
         for (int k = 0; k < SENSORS; k++) begin
            if (csr_we && csr_index == CSR_IDX_W'(k)) begin
               detect_ff[k] <= csr_data;
            end
            if (csr_we && csr_index == CSR_IDX_W'(SENSORS + k)) begin
               noise_ff[k] <= csr_data;
            end else if (step_en && adapt[k]) begin
               // rejected candidate: threshold drops to its reading
               noise_ff[k] <= readings[k];
            end
         end
      end
   end

   assign detect_level = detect_ff;
   assign noise_level  = noise_ff;

endmodule

// ===== sv/lgpd_select.sv =====
module lgpd_select import lgpd_pkg::*; (
   input  sample_arr_type   readings,
   input  sample_arr_type   noise_level,
   input  sample_arr_type   detect_level,
   input  logic [TRK_W-1:0] last_passed,
   output sel_type          sel
);

   logic [SENSORS-1:0] cand;
   logic [IDX_W-1:0]   expected;
   logic [IDX_W-1:0]   first;
   logic [IDX_W-1:0]   chosen;

   always_comb begin
      // next sensor in line after the last pass, sensor 0 when none yet
      if (last_passed < TRK_W'(SENSORS - 1)) begin
         expected = IDX_W'(last_passed + TRK_W'(1));
      end else begin
         expected = '0;
      end

      for (int k = 0; k < SENSORS; k++) begin
         cand[k] = readings[k] < noise_level[k];
      end

      first = '0;
      for (int k = SENSORS - 1; k >= 0; k--) begin
         if (cand[k]) begin
            first = IDX_W'(k);
         end
      end

      chosen = cand[expected] ? expected : first;

      for (int k = 0; k < SENSORS; k++) begin
         sel.adapt[k] = cand[k] && (IDX_W'(k) != chosen) && (readings[k] >= detect_level[k]);
      end

      sel.found        = |cand;
      sel.chosen       = chosen;
      sel.below_detect = readings[chosen] < detect_level[chosen];
   end

endmodule

// ===== sv/lgpd_track.sv =====
module lgpd_track import lgpd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  sel_type           sel,
   input  logic [TIME_W-1:0] now,
   output logic [TRK_W-1:0]  last_passed,
   output res_type           res
);

   logic [TRK_W-1:0]  tracking_ff, tracking_in;
   logic [TIME_W-1:0] below_ff, below_in;
   logic              reliable_ff, reliable_in;
   logic [TIME_W-1:0] prev_time_ff;
   logic [TRK_W-1:0]  last_ff, last_in;

   always_comb begin
      tracking_in = tracking_ff;
      below_in    = below_ff;
      reliable_in = reliable_ff;
      last_in     = last_ff;
      res         = '0;

      if (sel.found) begin
         if (TRK_W'(sel.chosen) == tracking_ff) begin
            below_in = below_ff + (now - prev_time_ff);
            if (sel.below_detect) begin
               reliable_in = 1'b1;
            end
         end else begin
            tracking_in = TRK_W'(sel.chosen);
            below_in    = '0;
            reliable_in = 1'b0;
         end
      end else if (tracking_ff != NO_SENSOR) begin
         if (reliable_ff) begin
            res.fire          = 1'b1;
            res.pass_sensor   = PASS_SENS_W'(tracking_ff);
            res.pass_duration = below_ff;
            reliable_in       = 1'b0;
            last_in           = tracking_ff;
         end
         below_in    = '0;
         tracking_in = NO_SENSOR;
      end

      res.tracking_sensor = tracking_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff  <= NO_SENSOR;
         below_ff     <= '0;
         reliable_ff  <= 1'b0;
         prev_time_ff <= '0;
         last_ff      <= NO_SENSOR;
      end else if (step_en) begin
         tracking_ff  <= tracking_in;
         below_ff     <= below_in;
         reliable_ff  <= reliable_in;
         prev_time_ff <= now;
         last_ff      <= last_in;
      end
   end

   assign last_passed = last_ff;

endmodule

// ===== sv/light_gate_pass_detector.sv =====
// channel  direction  handshake          payload
// req      in         req_valid/stall    sample_0..3, time_stamp
// rsp      out        rsp_valid/stall    fire, pass_sensor, pass_duration, tracking_sensor
// csr      in         csr_we             csr_index, csr_data
//
// one item per cycle while rsp is not stalled; each item passes the input
// register, then the scan and state update into the result register
// the scan and the tracking update fit between those two registers
// synchronous reset clears thresholds, tracking state and both valid flags
// a stalled rsp holds the result and backs up into req_stall
module light_gate_pass_detector import lgpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_W-1:0]    req_sample_0,
   input  logic [SAMPLE_W-1:0]    req_sample_1,
   input  logic [SAMPLE_W-1:0]    req_sample_2,
   input  logic [SAMPLE_W-1:0]    req_sample_3,
   input  logic [TIME_W-1:0]      req_time_stamp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_fire,
   output logic [PASS_SENS_W-1:0] rsp_pass_sensor,
   output logic [TIME_W-1:0]      rsp_pass_duration,
   output logic [TRACK_OUT_W-1:0] rsp_tracking_sensor,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic              in_valid_ff;
   sample_arr_type    in_sample_ff;
   logic [TIME_W-1:0] in_time_ff;
   logic              out_valid_ff;
   res_type           out_ff;

   logic              advance;
   logic              step_en;
   sample_arr_type    req_samples;
   sample_arr_type    detect_level;
   sample_arr_type    noise_level;
   logic [TRK_W-1:0]  last_passed;
   sel_type           sel;
   res_type           res;

   assign req_samples = {req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_samples;
         in_time_ff   <= req_time_stamp;
      end
      if (step_en) begin
         out_ff <= res;
      end
   end

   lgpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .step_en      (step_en),
      .adapt        (sel.adapt),
      .readings     (in_sample_ff),
      .detect_level (detect_level),
      .noise_level  (noise_level)
   );

   lgpd_select u_select (
      .readings     (in_sample_ff),
      .noise_level  (noise_level),
      .detect_level (detect_level),
      .last_passed  (last_passed),
      .sel          (sel)
   );

   lgpd_track u_track (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_en),
      .sel         (sel),
      .now         (in_time_ff),
      .last_passed (last_passed),
      .res         (res)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_fire            = out_ff.fire;
   assign rsp_pass_sensor     = out_ff.pass_sensor;
   assign rsp_pass_duration   = out_ff.pass_duration;
   assign rsp_tracking_sensor = TRACK_OUT_W'(out_ff.tracking_sensor);

endmodule

// ===== sv/lgpd_checker.sv =====
module lgpd_checker import lgpd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_fire,
   input logic [PASS_SENS_W-1:0] rsp_pass_sensor,
   input logic [TIME_W-1:0]      rsp_pass_duration,
   input logic [TRACK_OUT_W-1:0] rsp_tracking_sensor
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fire)
         && $stable(rsp_pass_sensor) && $stable(rsp_pass_duration)
         && $stable(rsp_tracking_sensor))
      else $error("rsp changed while stalled");

   // a finished pass leaves nothing tracked
   a_fire_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fire |-> rsp_tracking_sensor == TRACK_OUT_W'(SENSORS))
      else $error("fire while still tracking");

   // no pass, no pass payload
   a_quiet_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fire |-> rsp_pass_sensor == '0 && rsp_pass_duration == '0)
      else $error("pass payload without fire");

   // nothing is in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("valid item after reset");

endmodule

bind light_gate_pass_detector lgpd_checker u_lgpd_checker (.*);
